### design/osl_pkg.sv
// Shared types and constants of the oversampled sensor linearizer.
// No dependencies; compiled first.
`default_nettype none
package osl_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int VALUE_W    = 48;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W     = 8;
    localparam int MUL_MCW    = 48;
    localparam int MUL_LW     = 80;

    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_ADC_FAIL  = 2'd1;
    localparam t_status ST_DIV_FAULT = 2'd2;

    localparam t_cfg_idx REG_OVS    = 3'd0;
    localparam t_cfg_idx REG_FS     = 3'd1;
    localparam t_cfg_idx REG_RDIV   = 3'd2;
    localparam t_cfg_idx REG_COEF_A = 3'd3;
    localparam t_cfg_idx REG_COEF_B = 3'd4;
    localparam t_cfg_idx REG_COEF_C = 3'd5;

    localparam logic [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [62:0]        ATERM_CAP = 63'h4001_0000_0000_0000;

    // start pulse and number of bit steps for the serial units
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_seq_cmd;

endpackage
`default_nettype wire

### design/osl_if.sv
// Valid/ready channel interfaces for samples in and results out.
// Depends on osl_pkg.
`default_nettype none
interface osl_in_if;
    logic                          valid;
    logic                          ready;
    logic [osl_pkg::SAMPLE_W-1:0]  sample;
    logic                          sample_ok;
    modport source (output valid, output sample, output sample_ok, input ready);
    modport sink   (input valid, input sample, input sample_ok, output ready);
endinterface

interface osl_out_if;
    logic                          valid;
    logic                          ready;
    logic [osl_pkg::VALUE_W-1:0]   value;
    logic [osl_pkg::STATUS_W-1:0]  status;
    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

### design/osl_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on osl_pkg (command struct).
`default_nettype none
module osl_sdiv #(
    parameter int NW = 64,
    parameter int DW = 24
) (
    input  wire                logic         i_clk,
    input  wire                logic         i_rst_n,
    input  wire                osl_pkg::t_seq_cmd i_cmd,
    input  wire                logic [NW-1:0] i_numer,
    input  wire                logic [DW-1:0] i_divisor,
    output logic                             o_done,
    output logic               [NW-1:0]      o_quo
);
    import osl_pkg::*;

    logic [STEP_W-1:0] r_cnt;
    logic              r_done;
    logic [NW-1:0]     r_n;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_d;
    logic [DW:0]       w_sh;
    logic [DW:0]       w_diff;
    logic              w_ge;

    assign w_sh   = {r_rem, r_n[NW-1]};
    assign w_ge   = w_sh >= {1'b0, r_d};
    assign w_diff = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_cnt <= i_cmd.steps;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == STEP_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_n   <= i_numer;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
            r_n   <= {r_n[NW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_n;

endmodule
`default_nettype wire

### design/osl_smul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on osl_pkg (widths, command struct).
`default_nettype none
module osl_smul (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire osl_pkg::t_seq_cmd                             i_cmd,
    input  wire logic [osl_pkg::MUL_MCW-1:0]                   i_mcand,
    input  wire logic [osl_pkg::MUL_LW-1:0]                    i_mplier,
    output logic                                               o_done,
    output logic [osl_pkg::MUL_MCW+osl_pkg::MUL_LW-1:0]        o_prod
);
    import osl_pkg::*;

    logic [STEP_W-1:0]  r_cnt;
    logic               r_done;
    logic [MUL_MCW-1:0] r_mc;
    logic [MUL_MCW-1:0] r_hi;
    logic [MUL_LW-1:0]  r_lo;
    logic [MUL_MCW:0]   w_sum;

    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mc} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_cnt <= i_cmd.steps;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == STEP_W'(1));
            end
        end
    end

    // after k steps the product sits at {hi,lo} shifted up by MUL_LW-k
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mc <= i_mcand;
            r_hi <= '0;
            r_lo <= i_mplier;
        end else if (r_cnt != '0) begin
            {r_hi, r_lo} <= {w_sum, r_lo[MUL_LW-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule
`default_nettype wire

### design/oversampled_sensor_linearizer.sv
// Oversampled sensor linearizer: a sample that does not complete a group is added
// to the running sum. A failed sample clears the sum and gives its result through
// the output state. The sample that completes a group starts a bit-serial
// computation on one shared divider and one shared multiplier, one bit per cycle:
// the mean divide; unless the full-scale register is zero, the divider conversion
// as a multiply and a divide (a mean equal to full scale gives a divide fault);
// unless all coefficients are zero, the quadratic as three multiplies. Input is
// taken only while no group result is being computed; a finished result waits in
// the output register.
// Depends on osl_pkg, osl_if, osl_sdiv, osl_smul.
`default_nettype none
module oversampled_sensor_linearizer #(
    parameter int SAMPLE_BITS    = 16,
    parameter int MAX_OVERSAMPLE = 256
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    osl_in_if.sink                              i_smp,
    osl_out_if.source                           o_res,
    input  wire logic                           i_cfg_we,
    input  wire logic [osl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [osl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import osl_pkg::*;

    localparam int SUMW = SAMPLE_BITS + $clog2(MAX_OVERSAMPLE);
    localparam int CNTW = $clog2(MAX_OVERSAMPLE + 1);
    localparam int LIMW = (CNTW > 9) ? CNTW : 9;
    localparam int MW   = SAMPLE_BITS + 8;
    localparam int NUMW = SUMW + 8;
    localparam int NW   = MW + 40;
    localparam int DENW = (MW > 24) ? MW : 24;
    localparam int SINW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int PW   = MUL_MCW + MUL_LW;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_MDIV = 10'b00_0000_0010,
        S_DMUL = 10'b00_0000_0100,
        S_DDIV = 10'b00_0000_1000,
        S_QCHK = 10'b00_0001_0000,
        S_QMA  = 10'b00_0010_0000,
        S_QMX  = 10'b00_0100_0000,
        S_QMB  = 10'b00_1000_0000,
        S_QSUM = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } t_state;

    // configuration
    logic [8:0]  r_ovs;
    logic [23:0] r_fs;
    logic [31:0] r_rdiv;
    logic [31:0] r_ca, r_cb, r_cc;

    t_state              r_state, n_state;
    logic [SUMW-1:0]     r_sum, n_sum;
    logic [CNTW-1:0]     r_cnt, n_cnt;
    logic [VALUE_W-1:0]  r_x, n_x;
    logic [VALUE_W-1:0]  r_ax, n_ax;
    logic [65:0]         r_acc, n_acc;
    logic                r_dneg, n_dneg;
    logic [DENW-1:0]     r_dmag, n_dmag;
    logic [VALUE_W-1:0]  r_res_val, n_res_val;
    t_status             r_res_st, n_res_st;
    logic                r_ovalid;
    logic [VALUE_W-1:0]  r_oval;
    t_status             r_ost;

    t_seq_cmd            w_mul_cmd, w_div_cmd;
    logic [MUL_MCW-1:0]  w_mcand;
    logic [MUL_LW-1:0]   w_mplier;
    logic                w_mul_done, w_div_done;
    logic [PW-1:0]       w_prod;
    logic [NW-1:0]       w_numer, w_quo;
    logic [DENW-1:0]     w_divisor;

    logic                w_acc_in;
    logic [SUMW-1:0]     w_nsum;
    logic [CNTW-1:0]     w_ncnt;
    logic [LIMW-1:0]     w_lim;
    logic                w_last;
    logic [MW-1:0]       w_mean;
    logic [DENW:0]       w_dsub;
    logic [DENW-1:0]     w_dmag;
    logic                w_ovf;
    logic [VALUE_W-1:0]  w_qm, w_xq, w_ax;
    logic [31:0]         w_amag, w_bmag;
    logic [95:0]         w_t;
    logic [62:0]         w_av;
    logic [63:0]         w_bv;
    logic [65:0]         w_aterm, w_bterm, w_s;
    logic                w_fits, w_slot;

    osl_sdiv #(.NW(NW), .DW(DENW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_div_cmd), .i_numer(w_numer),
        .i_divisor(w_divisor), .o_done(w_div_done), .o_quo(w_quo)
    );

    osl_smul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_mul_cmd), .i_mcand(w_mcand),
        .i_mplier(w_mplier), .o_done(w_mul_done), .o_prod(w_prod)
    );

    assign i_smp.ready = (r_state == S_IDLE);
    assign w_acc_in    = i_smp.valid && (r_state == S_IDLE);
    assign w_slot      = !r_ovalid || o_res.ready;

    assign w_nsum = r_sum + SUMW'(i_smp.sample[SINW-1:0]);
    assign w_ncnt = r_cnt + 1'b1;
    assign w_lim  = (r_ovs == 9'd0) ? LIMW'(1) :
                    (LIMW'(r_ovs) > LIMW'(MAX_OVERSAMPLE)) ? LIMW'(MAX_OVERSAMPLE) :
                    LIMW'(r_ovs);
    assign w_last = LIMW'(w_ncnt) >= w_lim;

    assign w_mean = w_quo[MW-1:0];
    assign w_dsub = {1'b0, DENW'(r_fs)} - {1'b0, DENW'(w_mean)};
    assign w_dmag = w_dsub[DENW] ? DENW'(-w_dsub) : w_dsub[DENW-1:0];

    assign w_ovf  = |w_quo[NW-1:47];
    assign w_qm   = w_ovf ? VMIN : {1'b0, w_quo[46:0]};
    assign w_xq   = r_dneg ? (VALUE_W'(0) - w_qm) : (w_qm[47] ? VMAX : w_qm);

    assign w_ax   = r_x[47] ? (VALUE_W'(0) - r_x) : r_x;
    assign w_amag = r_ca[31] ? (32'd0 - r_ca) : r_ca;
    assign w_bmag = r_cb[31] ? (32'd0 - r_cb) : r_cb;

    assign w_t     = w_prod[PW-1:32];
    assign w_av    = (w_t > 96'(ATERM_CAP)) ? ATERM_CAP : w_t[62:0];
    assign w_aterm = r_ca[31] ? (66'd0 - 66'(w_av)) : 66'(w_av);
    assign w_bv    = w_prod[111:48];
    assign w_bterm = (r_cb[31] ^ r_x[47]) ? (66'd0 - 66'(w_bv)) : 66'(w_bv);
    assign w_s     = r_acc + {{34{r_cc[31]}}, r_cc};
    assign w_fits  = (w_s[65:47] == '0) || (w_s[65:47] == '1);

    always_comb begin
        n_state   = r_state;
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        n_x       = r_x;
        n_ax      = r_ax;
        n_acc     = r_acc;
        n_dneg    = r_dneg;
        n_dmag    = r_dmag;
        n_res_val = r_res_val;
        n_res_st  = r_res_st;
        w_mul_cmd = '0;
        w_div_cmd = '0;
        w_mcand   = '0;
        w_mplier  = '0;
        w_numer   = NW'({w_nsum, 8'h00}) << (NW - NUMW);
        w_divisor = DENW'(w_ncnt);
        unique case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    if (!i_smp.sample_ok) begin
                        n_sum     = '0;
                        n_cnt     = '0;
                        n_res_val = '0;
                        n_res_st  = ST_ADC_FAIL;
                        n_state   = S_OUT;
                    end else if (w_last) begin
                        n_sum     = '0;
                        n_cnt     = '0;
                        w_div_cmd = '{start: 1'b1, steps: STEP_W'(NUMW)};
                        n_state   = S_MDIV;
                    end else begin
                        n_sum = w_nsum;
                        n_cnt = w_ncnt;
                    end
                end
            end
            S_MDIV: begin
                if (w_div_done) begin
                    if (r_fs == 24'd0) begin
                        n_x     = VALUE_W'({w_mean, 8'h00});
                        n_state = S_QCHK;
                    end else if (w_dsub == '0) begin
                        n_res_val = VMAX;
                        n_res_st  = ST_DIV_FAULT;
                        n_state   = S_OUT;
                    end else begin
                        n_dneg    = w_dsub[DENW];
                        n_dmag    = w_dmag;
                        w_mcand   = MUL_MCW'(r_rdiv);
                        w_mplier  = MUL_LW'(w_mean);
                        w_mul_cmd = '{start: 1'b1, steps: STEP_W'(MW)};
                        n_state   = S_DMUL;
                    end
                end
            end
            S_DMUL: begin
                if (w_mul_done) begin
                    w_numer   = {w_prod[MUL_LW-MW +: MW+32], 8'h00};
                    w_divisor = r_dmag;
                    w_div_cmd = '{start: 1'b1, steps: STEP_W'(NW)};
                    n_state   = S_DDIV;
                end
            end
            S_DDIV: begin
                if (w_div_done) begin
                    n_x     = w_xq;
                    n_state = S_QCHK;
                end
            end
            S_QCHK: begin
                if (r_ca == '0 && r_cb == '0 && r_cc == '0) begin
                    n_res_val = r_x;
                    n_res_st  = ST_OK;
                    n_state   = S_OUT;
                end else begin
                    n_ax      = w_ax;
                    w_mcand   = MUL_MCW'(w_amag);
                    w_mplier  = MUL_LW'(w_ax);
                    w_mul_cmd = '{start: 1'b1, steps: STEP_W'(48)};
                    n_state   = S_QMA;
                end
            end
            S_QMA: begin
                if (w_mul_done) begin
                    w_mcand   = r_ax;
                    w_mplier  = w_prod[32 +: MUL_LW];
                    w_mul_cmd = '{start: 1'b1, steps: STEP_W'(MUL_LW)};
                    n_state   = S_QMX;
                end
            end
            S_QMX: begin
                if (w_mul_done) begin
                    n_acc     = w_aterm;
                    w_mcand   = MUL_MCW'(w_bmag);
                    w_mplier  = MUL_LW'(r_ax);
                    w_mul_cmd = '{start: 1'b1, steps: STEP_W'(48)};
                    n_state   = S_QMB;
                end
            end
            S_QMB: begin
                if (w_mul_done) begin
                    n_acc   = r_acc + w_bterm;
                    n_state = S_QSUM;
                end
            end
            S_QSUM: begin
                n_res_val = w_fits ? w_s[VALUE_W-1:0] : (w_s[65] ? VMIN : VMAX);
                n_res_st  = ST_OK;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (w_slot) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_ovs    <= 9'd1;
            r_fs     <= '0;
            r_rdiv   <= '0;
            r_ca     <= '0;
            r_cb     <= '0;
            r_cc     <= '0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
            if (r_state == S_OUT && w_slot) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_OVS:    r_ovs  <= i_cfg_data[8:0];
                    REG_FS:     r_fs   <= i_cfg_data[23:0];
                    REG_RDIV:   r_rdiv <= i_cfg_data;
                    REG_COEF_A: r_ca   <= i_cfg_data;
                    REG_COEF_B: r_cb   <= i_cfg_data;
                    REG_COEF_C: r_cc   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_ax      <= n_ax;
        r_acc     <= n_acc;
        r_dneg    <= n_dneg;
        r_dmag    <= n_dmag;
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
        if (r_state == S_OUT && w_slot) begin
            r_oval <= r_res_val;
            r_ost  <= r_res_st;
        end
    end

    assign o_res.valid  = r_ovalid;
    assign o_res.value  = r_oval;
    assign o_res.status = r_ost;

    a_fault_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_DIV_FAULT) |-> (o_res.value == VMAX))
        else $error("divide fault without saturated value");

    a_fail_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_ADC_FAIL) |-> (o_res.value == '0))
        else $error("adc failure with nonzero value");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNTW'(MAX_OVERSAMPLE))
        else $error("sample count beyond group size");

    a_fail_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready && !i_smp.sample_ok)
            |=> (r_state == S_OUT && r_sum == '0 && r_cnt == '0))
        else $error("failed sample did not clear the partial sum");

endmodule
`default_nettype wire
